// ===== src/capp_pkg.sv =====
// Shared types, constants and saturation helper for the cascaded altitude controller.
package capp_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_DIVISOR = 25;
    localparam int DIV_PRESHIFT = 20;
    localparam int DIV_W = 40;
    localparam int DIV_STEPS = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
    localparam int DIV_REM_W = $clog2(DIV_DIVISOR);
    localparam int QUOT_W = DATA_W + 1;

    localparam logic [DIV_W-1:0] DIV_SAT_DIVIDEND = DIV_W'(DIV_DIVISOR) << DATA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_ENABLE = 3'd0,
        REG_ALT_GAIN_P  = 3'd1,
        REG_ALT_GAIN_I  = 3'd2,
        REG_VEL_GAIN_P  = 3'd3,
        REG_OUT_MAX     = 3'd4,
        REG_OUT_MIN     = 3'd5
    } cfg_index_t;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL_I = 9'b000000010,
        S_PREP  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_INT   = 9'b000010000,
        S_VSET  = 9'b000100000,
        S_VERR  = 9'b001000000,
        S_MUL_V = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
        min_v = -max_v - PROD_W'(1);
        if (v > max_v) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < min_v) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== src/capp_div25.sv =====
// Iterative restoring divider by a small constant, several quotient bits per cycle.
module capp_div25
    import capp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    output logic              done,
    output logic [QUOT_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     work_reg, work_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;

    logic [DIV_W-1:0]     step_work;
    logic [DIV_REM_W-1:0] step_rem;
    logic [DIV_REM_W:0]   trial;

    always_comb begin
        step_work = work_reg;
        step_rem  = rem_reg;
        trial     = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial     = {step_rem, step_work[DIV_W-1]};
            step_work = {step_work[DIV_W-2:0], 1'b0};
            if (trial >= (DIV_REM_W+1)'(DIV_DIVISOR)) begin
                step_rem     = DIV_REM_W'(trial - (DIV_REM_W+1)'(DIV_DIVISOR));
                step_work[0] = 1'b1;
            end else begin
                step_rem = trial[DIV_REM_W-1:0];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            work_next = step_work;
            rem_next  = step_rem;
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
        end
        work_reg <= work_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg[QUOT_W-1:0];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < DIV_REM_W'(DIV_DIVISOR))
        else $error("divider remainder out of range");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// ===== src/cascaded_altitude_pi_p_control.sv =====
// Top level of the cascaded altitude PI and velocity P controller.
//
// Each control tick arrives as one transfer on the s_ stream: tdata carries the altitude
// setpoint, the measured altitude and the measured climb rate, all signed Q16.16, and
// tuser carries the flag that clears the altitude integral before this tick's update.
// Each tick yields one transfer on the m_ stream with the clamped throttle adjustment and
// the climb rate setpoint. Gains and clamp limits are to be written through the cfg_ write
// port while the block is idle; the block itself does not enforce this.
// A single 32 by 32 multiplier serves all three products in turn, and the integral step
// goes through a divider by 25 that retires eight quotient bits per cycle. The block takes
// the next tick only once the current result has been loaded into the output register;
// with the loop disabled a tick skips the computation and yields zeros without touching
// the integral.
// The block accepts a new tick while a finished result still waits in the output register;
// when the receiver stalls, the following result waits in its final step until that
// register is free. Reset clears the configuration, the integral and all handshake state.
module cascaded_altitude_pi_p_control
    import capp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // alt_target[31:0], alt_measured[63:32], climb_rate[95:64]
    input  logic [3*DATA_W-1:0]  s_tdata,
    // clear_integral[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // throttle_adjust[31:0], climb_rate_target[63:32]
    output logic [2*DATA_W-1:0]  m_tdata
);

    state_t state_reg, state_next;

    logic                     loop_enable_reg;
    logic signed [DATA_W-1:0] alt_gain_p_reg, alt_gain_i_reg, vel_gain_p_reg;
    logic signed [DATA_W-1:0] out_max_reg, out_min_reg;

    logic signed [DATA_W-1:0] integral_reg, integral_next;
    logic signed [DATA_W-1:0] err_reg, rate_reg, vset_reg, verr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     bypass_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_thr_reg, out_vset_reg;

    logic signed [DATA_W-1:0] in_target, in_meas, in_rate;
    logic signed [DATA_W:0]   in_diff;
    logic                     in_fire;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     mul_en;

    logic [PROD_W-1:0]        prod_mag;
    logic [PROD_W-1:0]        prod_scaled;
    logic [DIV_W-1:0]         div_dividend;
    logic                     div_start;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;

    logic signed [QUOT_W:0]   incr;
    logic signed [QUOT_W+1:0] int_sum;
    logic signed [PROD_W-1:0] vset_sum;
    logic signed [DATA_W:0]   verr_diff;
    logic signed [DATA_W-1:0] thr_sat, thr_clamped;
    logic                     out_load;

    assign in_target = s_tdata[DATA_W-1:0];
    assign in_meas   = s_tdata[2*DATA_W-1:DATA_W];
    assign in_rate   = s_tdata[3*DATA_W-1:2*DATA_W];
    assign in_diff   = (DATA_W+1)'(in_target) - (DATA_W+1)'(in_meas);

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_enable_reg <= 1'b0;
            alt_gain_p_reg  <= '0;
            alt_gain_i_reg  <= '0;
            vel_gain_p_reg  <= '0;
            out_max_reg     <= '0;
            out_min_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LOOP_ENABLE: loop_enable_reg <= cfg_wdata[0];
                REG_ALT_GAIN_P:  alt_gain_p_reg  <= cfg_wdata;
                REG_ALT_GAIN_I:  alt_gain_i_reg  <= cfg_wdata;
                REG_VEL_GAIN_P:  vel_gain_p_reg  <= cfg_wdata;
                REG_OUT_MAX:     out_max_reg     <= cfg_wdata;
                REG_OUT_MIN:     out_min_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        mul_en = 1'b1;
        unique case (state_reg)
            S_MUL_I: begin
                mul_a = err_reg;
                mul_b = alt_gain_i_reg;
            end
            S_PREP: begin
                mul_a = alt_gain_p_reg;
                mul_b = err_reg;
            end
            S_MUL_V: begin
                mul_a = vel_gain_p_reg;
                mul_b = verr_reg;
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_mag    = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign prod_scaled = prod_mag >> DIV_PRESHIFT;
    assign div_dividend = (prod_scaled >= PROD_W'(DIV_SAT_DIVIDEND)) ?
                          DIV_SAT_DIVIDEND : prod_scaled[DIV_W-1:0];
    assign div_start   = (state_reg == S_PREP);

    capp_div25 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign incr    = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign int_sum = (QUOT_W+2)'(integral_reg) + (QUOT_W+2)'(incr);
    assign vset_sum  = (prod_reg >>> 16) + PROD_W'(integral_reg);
    assign verr_diff = (DATA_W+1)'(vset_reg) - (DATA_W+1)'(rate_reg);
    assign thr_sat   = sat32(prod_reg >>> 16);

    always_comb begin
        priority if (thr_sat > out_max_reg) begin
            thr_clamped = out_max_reg;
        end else if (thr_sat < out_min_reg) begin
            thr_clamped = out_min_reg;
        end else begin
            thr_clamped = thr_sat;
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        integral_next = integral_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (loop_enable_reg) begin
                        state_next = S_MUL_I;
                        if (s_tuser) begin
                            integral_next = '0;
                        end
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL_I: state_next = S_PREP;
            S_PREP:  state_next = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    state_next = S_INT;
                end
            end
            S_INT: begin
                integral_next = sat32(PROD_W'(int_sum));
                state_next    = S_VSET;
            end
            S_VSET:  state_next = S_VERR;
            S_VERR:  state_next = S_MUL_V;
            S_MUL_V: state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            integral_reg <= integral_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            err_reg    <= sat32(PROD_W'(in_diff));
            rate_reg   <= in_rate;
            bypass_reg <= !loop_enable_reg;
        end
        if (mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == S_PREP) begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        if (state_reg == S_VSET) begin
            vset_reg <= sat32(vset_sum);
        end
        if (state_reg == S_VERR) begin
            verr_reg <= sat32(PROD_W'(verr_diff));
        end
        if (out_load) begin
            out_thr_reg  <= bypass_reg ? '0 : thr_clamped;
            out_vset_reg <= bypass_reg ? '0 : vset_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_vset_reg, out_thr_reg};

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    a_integral_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_INT && !in_fire) |=> $stable(integral_reg))
        else $error("integral changed outside its update step");

    a_result_from_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared without a final step");

    a_disabled_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && bypass_reg) |=> (m_tdata == '0))
        else $error("disabled tick produced a nonzero result");

endmodule
